/* rtl/rdc_pkg.sv */
// Package for the radix digit converter: widths, sequencer states and the
// radix clamp function. No dependencies.
package rdc_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int DIGIT_SLOTS = 32;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int ADDR_W      = $clog2(DIGIT_SLOTS);
  localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
  localparam int STEP_W      = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_LAUNCH,
    ST_WAIT,
    ST_READ,
    ST_EMIT
  } state_t;

  // Status returned by the shared divider at the end of one division.
  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_status_t;

  // Saturate the programmed radix into the usable range of two to sixteen.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

endpackage

/* rtl/rdc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rdc_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle by a small divisor.
// Depends on rdc_pkg.
module rdc_divider
  import rdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output div_status_t           status
);

  logic [VALUE_BITS-1:0] work;
  logic [RADIX_W-1:0]    rem;
  logic [RADIX_W-1:0]    dvsr;
  logic [STEP_W-1:0]     step;
  logic                  active;
  logic                  done;

  logic [RADIX_W:0]      trial;
  logic                  fits;
  logic [RADIX_W:0]      diff;

  always_comb begin
    trial = {rem, work[VALUE_BITS-1]};
    fits  = (trial >= {1'b0, dvsr});
    diff  = trial - {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(VALUE_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (active) begin
      work <= {work[VALUE_BITS-2:0], fits};
      rem  <= fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    end
  end

  // The remainder stays below the divisor, which is at most sixteen.
  assign status.done      = done;
  assign status.quotient  = work;
  assign status.remainder = rem[DIGIT_W-1:0];

endmodule

/* rtl/radix_digit_converter.sv */
// Top level of the radix digit converter: sequencer, digit store and divider.
// Depends on rdc_pkg, rdc_divider and rdc_ram.
//
// Usage. A conversion request is a transfer on the command channel: value is
// taken at a rising edge where start is high and busy is low. busy then stays
// high until the last result of that conversion has been shown.
// The radix register is written through its own channel (cfg_valid,
// cfg_ready, cfg_radix); cfg_ready is always high, and writes are expected
// only while busy is low. Programmed radix values below two act as two and
// values above sixteen act as sixteen. Reset sets the radix to ten.
// Results leave on digit, last_digit and empty_result, each shown for exactly
// one cycle while digit_valid is high; the receiver cannot hold them off.
// Digits come most significant first and last_digit marks the final one.
// A zero value gives one result with digit zero and empty_result set.
// Each digit costs one pass of the shared bit-serial divider, one quotient bit
// per cycle, launched in ST_LAUNCH and collected in ST_WAIT. After the last
// division the ST_READ state primes the digit store read, and then one digit
// is shown per cycle.
// Synchronous active-high reset returns the sequencer to idle and drops any
// conversion in progress; the digit store holds no reset state.
module radix_digit_converter
  import rdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RADIX_W-1:0]    cfg_radix,
  output logic                  digit_valid,
  output logic [DIGIT_W-1:0]    digit,
  output logic                  last_digit,
  output logic                  empty_result
);

  state_t state, state_next;

  logic [RADIX_W-1:0]    radix;
  logic [VALUE_BITS-1:0] quotient_reg;
  logic [CNT_W-1:0]      digit_count;
  logic [ADDR_W-1:0]     rd_ptr;
  logic [ADDR_W-1:0]     emit_idx;

  logic                  accept;
  logic                  div_start;
  div_status_t           div_status;
  logic [CNT_W-1:0]      count_inc;
  logic                  more_digits;
  logic [DIGIT_W-1:0]    ram_rdata;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign count_inc = digit_count + CNT_W'(1);
  // Keep dividing while a quotient remains and the store still has room.
  assign more_digits = (div_status.quotient != '0) && (count_inc < CNT_W'(DIGIT_SLOTS));

  // Radix register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_radix;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (value == '0) ? ST_ZERO : ST_LAUNCH;
        end
      end
      ST_ZERO:   state_next = ST_IDLE;
      ST_LAUNCH: state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_status.done) begin
          state_next = more_digits ? ST_LAUNCH : ST_READ;
        end
      end
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_idx == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output decode of the sequencer.
  always_comb begin
    busy         = 1'b1;
    div_start    = 1'b0;
    digit_valid  = 1'b0;
    digit        = ram_rdata;
    last_digit   = 1'b0;
    empty_result = 1'b0;
    unique case (state)
      ST_IDLE:   busy = 1'b0;
      ST_ZERO: begin
        digit_valid  = 1'b1;
        digit        = '0;
        last_digit   = 1'b1;
        empty_result = 1'b1;
      end
      ST_LAUNCH: div_start = 1'b1;
      ST_WAIT:   ;
      ST_READ:   ;
      ST_EMIT: begin
        digit_valid = 1'b1;
        last_digit  = (emit_idx == '0);
      end
      default:   ;
    endcase
  end

  // Datapath registers: running quotient, digit count and read pointers.
  // The read pointer runs one slot ahead of the digit on the store output.
  always_ff @(posedge clk) begin
    if (rst) begin
      quotient_reg <= '0;
      digit_count  <= '0;
    end else begin
      if (accept) begin
        quotient_reg <= value;
        digit_count  <= '0;
      end else if (state == ST_WAIT && div_status.done) begin
        quotient_reg <= div_status.quotient;
        digit_count  <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAIT && div_status.done) begin
      rd_ptr <= digit_count[ADDR_W-1:0];
    end else if (state == ST_READ || (state == ST_EMIT && emit_idx != '0)) begin
      emit_idx <= rd_ptr;
      rd_ptr   <= rd_ptr - ADDR_W'(1);
    end
  end

  rdc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (quotient_reg),
    .divisor  (clamp_radix(radix)),
    .status   (div_status)
  );

  // Remainders are stored least significant first, one slot per division.
  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_SLOTS)
  ) u_digit_store (
    .clk   (clk),
    .we    (state == ST_WAIT && div_status.done),
    .waddr (digit_count[ADDR_W-1:0]),
    .wdata (div_status.remainder),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

endmodule
